>>> design/pbrs_pkg.sv
// shared types, sizes and operation codes for the priority bitmap ready scheduler
`timescale 1ns / 1ps
`default_nettype none

package pbrs_pkg;

  // sizes of the thread table and the level table
  localparam int THREAD_COUNT    = 32;
  localparam int PRIORITY_LEVELS = 32;
  localparam int TID_W           = 5;
  localparam int LVL_W           = 5;

  // operation codes carried in the mode field
  localparam logic [1:0] MODE_INSERT = 2'd0;
  localparam logic [1:0] MODE_REMOVE = 2'd1;
  localparam logic [1:0] MODE_MOVE   = 2'd2;

  // one operation as held in the input register
  typedef struct packed {
    logic [1:0]       mode;
    logic [TID_W-1:0] thread_id;
    logic [LVL_W-1:0] priority_req;
  } pbrs_cmd_t;

  // one result as held in the output register
  typedef struct packed {
    logic             op_error;
    logic [LVL_W-1:0] highest_priority;
    logic [TID_W-1:0] highest_thread;
    logic             highest_valid;
  } pbrs_res_t;

  // lowest set bit of one byte
  function automatic logic [2:0] ffs8(input logic [7:0] b);
    logic [2:0] idx;
    idx = 3'd0;
    for (int i = 7; i >= 0; i--) begin
      if (b[i]) idx = 3'(i);
    end
    return idx;
  endfunction

endpackage

`default_nettype wire

>>> design/pbrs_ffs.sv
// find-first-set over the ready bitmap, done as byte encoders plus a byte select
`timescale 1ns / 1ps
`default_nettype none

module pbrs_ffs
  import pbrs_pkg::*;
(
  input  wire logic [PRIORITY_LEVELS-1:0] bitmap_i,
  output logic                            any_o,
  output logic [LVL_W-1:0]                first_o
);

  localparam int GROUPS = PRIORITY_LEVELS / 8;
  localparam int GRP_W  = LVL_W - 3;

  logic [GROUPS-1:0] grp_any;
  logic [2:0]        grp_idx [GROUPS];
  logic [GRP_W-1:0]  sel;

  // per byte: any bit set and its lowest set bit
  always_comb begin
    for (int g = 0; g < GROUPS; g++) begin
      grp_any[g] = |bitmap_i[g*8 +: 8];
      grp_idx[g] = ffs8(bitmap_i[g*8 +: 8]);
    end
  end

  // pick the lowest byte that has a bit set
  always_comb begin
    sel = '0;
    for (int g = GROUPS - 1; g >= 0; g--) begin
      if (grp_any[g]) sel = GRP_W'(g);
    end
  end

  assign any_o   = |grp_any;
  assign first_o = any_o ? {sel, grp_idx[sel]} : '0;

endmodule

`default_nettype wire

>>> design/pbrs_ready_lists.sv
// ready bitmap, level heads and per-thread links, updated by one operation a cycle while apply_i is high
`timescale 1ns / 1ps
`default_nettype none

module pbrs_ready_lists
  import pbrs_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire pbrs_cmd_t cmd_i,
  input  wire logic      apply_i,
  output pbrs_res_t      res_o
);

  logic [PRIORITY_LEVELS-1:0] bitmap_q, bitmap_d;
  logic [TID_W-1:0]           head_q   [PRIORITY_LEVELS];
  logic [TID_W-1:0]           head_d   [PRIORITY_LEVELS];
  logic [THREAD_COUNT-1:0]    ready_q, ready_d;
  logic [TID_W-1:0]           next_q   [THREAD_COUNT];
  logic [TID_W-1:0]           next_d   [THREAD_COUNT];
  logic [TID_W-1:0]           prev_q   [THREAD_COUNT];
  logic [TID_W-1:0]           prev_d   [THREAD_COUNT];
  logic [LVL_W-1:0]           level_q  [THREAD_COUNT];
  logic [LVL_W-1:0]           level_d  [THREAD_COUNT];

  logic             err;
  logic             any_ready;
  logic [LVL_W-1:0] best_lvl;

  // apply the operation: unlink from the old level, then append at the new tail
  always_comb begin
    logic [TID_W-1:0] t, n, p, h, tl;
    logic [LVL_W-1:0] l, ul;
    logic             tid_bad, lvl_bad, do_unlink, do_append;
    t  = cmd_i.thread_id;
    l  = cmd_i.priority_req;
    bitmap_d = bitmap_q;
    head_d   = head_q;
    ready_d  = ready_q;
    next_d   = next_q;
    prev_d   = prev_q;
    level_d  = level_q;
    tid_bad  = ({1'b0, t} >= (TID_W+1)'(THREAD_COUNT));
    lvl_bad  = ({1'b0, l} >= (LVL_W+1)'(PRIORITY_LEVELS));
    do_unlink = 1'b0;
    do_append = 1'b0;
    err       = 1'b0;
    if (tid_bad) begin
      err = 1'b1;
    end else begin
      case (cmd_i.mode)
        MODE_INSERT: begin
          err       = ready_q[t] | lvl_bad;
          do_append = ~err;
        end
        MODE_REMOVE: begin
          err       = ~ready_q[t];
          do_unlink = ~err;
        end
        MODE_MOVE: begin
          err       = ~ready_q[t] | lvl_bad;
          do_unlink = ~err;
          do_append = ~err;
        end
        default: err = 1'b1;
      endcase
    end

    // unlink from the stored level
    ul = level_q[t];
    n  = next_q[t];
    p  = prev_q[t];
    if (do_unlink) begin
      if (n == t) begin
        head_d[ul]   = '0;
        bitmap_d[ul] = 1'b0;
      end else begin
        next_d[p] = n;
        prev_d[n] = p;
        if (head_q[ul] == t) head_d[ul] = n;
      end
      ready_d[t] = 1'b0;
    end

    // append at the tail, on the state left by the unlink
    h  = head_d[l];
    tl = prev_d[h];
    if (do_append) begin
      if (!bitmap_d[l]) begin
        head_d[l]   = t;
        next_d[t]   = t;
        prev_d[t]   = t;
        bitmap_d[l] = 1'b1;
      end else begin
        next_d[t]  = h;
        prev_d[t]  = tl;
        next_d[tl] = t;
        prev_d[h]  = t;
      end
      level_d[t] = l;
      ready_d[t] = 1'b1;
    end
  end

  // most urgent nonempty level after the operation
  pbrs_ffs u_ffs (
    .bitmap_i (bitmap_d),
    .any_o    (any_ready),
    .first_o  (best_lvl)
  );

  assign res_o.highest_valid    = any_ready;
  assign res_o.highest_thread   = any_ready ? head_d[best_lvl] : '0;
  assign res_o.highest_priority = best_lvl;
  assign res_o.op_error         = err;

  // control state: bitmap, heads and ready flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bitmap_q <= '0;
      ready_q  <= '0;
      for (int i = 0; i < PRIORITY_LEVELS; i++) head_q[i] <= '0;
    end else if (apply_i) begin
      bitmap_q <= bitmap_d;
      ready_q  <= ready_d;
      head_q   <= head_d;
    end
  end

  // link and level tables, read only for ready threads
  always_ff @(posedge clk_i) begin
    if (apply_i) begin
      next_q  <= next_d;
      prev_q  <= prev_d;
      level_q <= level_d;
    end
  end

endmodule

`default_nettype wire

>>> design/priority_bitmap_ready_scheduler.sv
// top level: input register, ready list update and result register
// path: an accepted transaction waits in the input register and moves to the result register when advance is high
// throughput: one operation per cycle while the result side does not stall; the list update
// and the 32-bit find-first-set that follows it are combinational between the two registers
// reset: all levels empty and no thread ready; both registers empty
`timescale 1ns / 1ps
`default_nettype none

module priority_bitmap_ready_scheduler
  import pbrs_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  // [1:0] mode, [6:2] thread_id, [11:7] priority_req, [15:12] zero
  input  wire logic [15:0] s_axis_tdata_i,
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  // [0] highest_valid, [5:1] highest_thread, [10:6] highest_priority,
  // [11] op_error, [15:12] zero
  output logic [15:0]      m_axis_tdata_o
);

  logic      in_valid_q;
  pbrs_cmd_t cmd_q;
  logic      out_valid_q;
  pbrs_res_t res_q, res_d;
  logic      advance;

  assign advance         = in_valid_q & (~out_valid_q | m_axis_tready_i);
  assign s_axis_tready_o = ~in_valid_q | advance;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      in_valid_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready_o && s_axis_tvalid_i) begin
      cmd_q.mode         <= s_axis_tdata_i[1:0];
      cmd_q.thread_id    <= s_axis_tdata_i[6:2];
      cmd_q.priority_req <= s_axis_tdata_i[11:7];
    end
  end

  // list state and result logic
  pbrs_ready_lists u_lists (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cmd_i   (cmd_q),
    .apply_i (advance),
    .res_o   (res_d)
  );

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) res_q <= res_d;
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {4'b0000, res_q.op_error, res_q.highest_priority,
                            res_q.highest_thread, res_q.highest_valid};

endmodule

`default_nettype wire

>>> design/pbrs_checker.sv
// port-level assertions for the scheduler, bound to the top level
`timescale 1ns / 1ps
`default_nettype none

module pbrs_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        s_axis_tvalid_i,
  input wire logic        s_axis_tready_o,
  input wire logic [15:0] s_axis_tdata_i,
  input wire logic        m_axis_tvalid_o,
  input wire logic        m_axis_tready_i,
  input wire logic [15:0] m_axis_tdata_o
);

  // no result is offered after an edge that sees reset
  assert property (@(posedge clk_i) !rst_ni |=> !m_axis_tvalid_o)
    else $error("result offered during reset");

  // a stalled result is held
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o))
    else $error("stalled result changed");

  // empty ready queue reports thread and level zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tdata_o[0] |-> m_axis_tdata_o[10:1] == 10'd0)
    else $error("empty queue with nonzero head fields");

  // padding bits of the result stay zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> m_axis_tdata_o[15:12] == 4'd0)
    else $error("result padding not zero");

  // an undefined mode is flagged once it has passed the input and result registers with nothing stalling
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o && s_axis_tdata_i[1:0] == 2'd3 && m_axis_tready_i
    ##1 m_axis_tready_i |=> m_axis_tvalid_o && m_axis_tdata_o[11])
    else $error("undefined mode not flagged");

endmodule

bind priority_bitmap_ready_scheduler pbrs_checker u_pbrs_checker (.*);

`default_nettype wire

>>> tb/sv/testbench.sv
// self-checking testbench for the priority bitmap ready scheduler
`timescale 1ns / 1ps

module testbench;
  import pbrs_pkg::*;

  // mode value with no operation behind it
  localparam logic [1:0] MODE_UNUSED = 2'd3;
  localparam int RANDOM_OPS = 1200;
  localparam int HOLD_OFF_CYCLES = 120;
  localparam int DRAIN_CYCLES = 10;
  localparam logic [7:0] STALL_PATTERN = 8'b1011_0110;

  // one row of the directed table
  typedef struct {
    pbrs_cmd_t cmd;
    bit        typed;
    pbrs_res_t res;
  } dir_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic [15:0] s_axis_tdata = '0;
  logic        m_axis_tready = 1'b0;
  logic        s_axis_tready_o;
  logic        m_axis_tvalid_o;
  logic [15:0] m_axis_tdata_o;

  // shadow copy of the ready lists
  logic [31:0] rq_bitmap;
  logic [4:0]  rq_head [32];
  logic [4:0]  rq_next [32];
  logic [4:0]  rq_prev [32];
  logic [4:0]  rq_level [32];
  logic        rq_ready [32];

  pbrs_res_t   sched_expect_q[$];
  dir_row_t    dir_rows[$];

  int          mismatch_count = 0;
  int          ops_sent = 0;
  int          results_seen = 0;
  int          n_insert = 0;
  int          n_remove = 0;
  int          n_move = 0;
  int          n_rejected = 0;
  int          deepest_ready = 0;
  int          burst_left = 0;
  bit          hold_off = 1'b0;

  priority_bitmap_ready_scheduler uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready),
    .m_axis_tdata_o  (m_axis_tdata_o)
  );

  // clock and reset
  always #5 clk_i = ~clk_i;

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  // run limit
  initial begin
    #(5_000_000);
    $display("[FAIL] regression broken");
    $finish;
  end

  // one line per mismatch, all of them counted
  task automatic report_mismatch(input string msg);
    $display("mismatch @%0t: %s", $realtime, msg);
    mismatch_count++;
  endtask

  task automatic check_field(input string name, input int got, input int want);
    if (got != want)
      report_mismatch($sformatf("result %0d %s got %0d expected %0d",
                                results_seen, name, got, want));
  endtask

  // take a thread out of its level's circular list
  function automatic void rq_unlink(input logic [4:0] t);
    logic [4:0] lvl;
    logic [4:0] n;
    logic [4:0] p;
    lvl = rq_level[t];
    n = rq_next[t];
    p = rq_prev[t];
    if (n == t) begin
      rq_head[lvl] = '0;
      rq_bitmap[lvl] = 1'b0;
    end else begin
      rq_next[p] = n;
      rq_prev[n] = p;
      if (rq_head[lvl] == t) rq_head[lvl] = n;
    end
    rq_ready[t] = 1'b0;
  endfunction

  // put a thread at the tail of a level
  function automatic void rq_append(input logic [4:0] t, input logic [4:0] lvl);
    logic [4:0] h;
    logic [4:0] tl;
    if (!rq_bitmap[lvl]) begin
      rq_head[lvl] = t;
      rq_next[t] = t;
      rq_prev[t] = t;
      rq_bitmap[lvl] = 1'b1;
    end else begin
      h = rq_head[lvl];
      tl = rq_prev[h];
      rq_next[t] = h;
      rq_prev[t] = tl;
      rq_next[tl] = t;
      rq_prev[h] = t;
    end
    rq_level[t] = lvl;
    rq_ready[t] = 1'b1;
  endfunction

  // apply one operation to the shadow lists and return the scheduling decision
  function automatic pbrs_res_t schedule_step(input pbrs_cmd_t c);
    pbrs_res_t r;
    logic      err;
    int        best;
    err = 1'b0;
    case (c.mode)
      MODE_INSERT: begin
        if (rq_ready[c.thread_id]) err = 1'b1;
        else rq_append(c.thread_id, c.priority_req);
      end
      MODE_REMOVE: begin
        if (!rq_ready[c.thread_id]) err = 1'b1;
        else rq_unlink(c.thread_id);
      end
      MODE_MOVE: begin
        if (!rq_ready[c.thread_id]) err = 1'b1;
        else begin
          rq_unlink(c.thread_id);
          rq_append(c.thread_id, c.priority_req);
        end
      end
      default: err = 1'b1;
    endcase
    // lowest set level wins
    best = 0;
    for (int i = 31; i >= 0; i--) begin
      if (rq_bitmap[i]) best = i;
    end
    r.op_error = err;
    r.highest_valid = |rq_bitmap;
    r.highest_thread = r.highest_valid ? rq_head[best] : 5'd0;
    r.highest_priority = r.highest_valid ? 5'(best) : 5'd0;
    return r;
  endfunction

  function automatic dir_row_t mk_row(input logic [1:0] mode, input int tid, input int lvl,
                                      input bit typed, input bit v, input int thr,
                                      input int pri, input bit err);
    dir_row_t row;
    row.cmd.mode = mode;
    row.cmd.thread_id = 5'(tid);
    row.cmd.priority_req = 5'(lvl);
    row.typed = typed;
    row.res.highest_valid = v;
    row.res.highest_thread = 5'(thr);
    row.res.highest_priority = 5'(pri);
    row.res.op_error = err;
    return row;
  endfunction

  // offer one operation, wait for the transaction, then maybe pause
  task automatic send_op(input pbrs_cmd_t c, input bit typed, input pbrs_res_t typed_res);
    pbrs_res_t pred;
    int        gap;
    int        depth;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {4'b0000, c.priority_req, c.thread_id, c.mode};
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    pred = schedule_step(c);
    sched_expect_q.push_back(typed ? typed_res : pred);
    ops_sent++;
    if (pred.op_error) n_rejected++;
    else if (c.mode == MODE_INSERT) n_insert++;
    else if (c.mode == MODE_REMOVE) n_remove++;
    else n_move++;
    depth = 0;
    for (int i = 0; i < 32; i++) depth += rq_ready[i];
    if (depth > deepest_ready) deepest_ready = depth;
    // bursts of random length, now and then a long one
    gap = 0;
    if (burst_left == 0) begin
      gap = $urandom_range(1, 8);
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 150)
                                               : $urandom_range(1, 20);
    end else begin
      burst_left--;
    end
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // random operation, mostly legal against the current ready set
  function automatic pbrs_cmd_t pick_op();
    pbrs_cmd_t c;
    int        roll;
    c.thread_id = 5'($urandom_range(0, 31));
    c.priority_req = ($urandom_range(0, 1) == 1) ? 5'($urandom_range(0, 3))
                                                 : 5'($urandom_range(0, 31));
    roll = $urandom_range(0, 99);
    if (roll < 4) begin
      c.mode = MODE_UNUSED;
    end else if (roll < 10) begin
      // illegal on purpose
      if (rq_ready[c.thread_id]) c.mode = MODE_INSERT;
      else c.mode = ($urandom_range(0, 1) == 1) ? MODE_REMOVE : MODE_MOVE;
    end else if (!rq_ready[c.thread_id]) begin
      c.mode = MODE_INSERT;
    end else if (roll < 55) begin
      c.mode = MODE_REMOVE;
    end else begin
      c.mode = MODE_MOVE;
      if (roll > 90) c.priority_req = rq_level[c.thread_id];
    end
    return c;
  endfunction

  // stimulus: directed table, random operations, drain, verdict
  initial begin : stimulus
    pbrs_cmd_t c;
    pbrs_res_t none;
    rq_bitmap = '0;
    for (int i = 0; i < 32; i++) begin
      rq_head[i] = '0;
      rq_next[i] = '0;
      rq_prev[i] = '0;
      rq_level[i] = '0;
      rq_ready[i] = 1'b0;
    end
    none = '0;
    // empty scheduler: every remove, move and unused mode is rejected
    dir_rows.push_back(mk_row(MODE_REMOVE, 0, 0, 1, 0, 0, 0, 1));
    dir_rows.push_back(mk_row(MODE_MOVE, 31, 17, 1, 0, 0, 0, 1));
    dir_rows.push_back(mk_row(MODE_UNUSED, 7, 3, 1, 0, 0, 0, 1));
    // extremes of thread and level
    dir_rows.push_back(mk_row(MODE_INSERT, 31, 31, 1, 1, 31, 31, 0));
    dir_rows.push_back(mk_row(MODE_INSERT, 0, 0, 1, 1, 0, 0, 0));
    // insert of a thread already ready
    dir_rows.push_back(mk_row(MODE_INSERT, 0, 3, 1, 1, 0, 0, 1));
    // list building, head removal, same-level move, middle removal
    dir_rows.push_back(mk_row(MODE_INSERT, 5, 0, 0, 0, 0, 0, 0));
    dir_rows.push_back(mk_row(MODE_INSERT, 9, 0, 0, 0, 0, 0, 0));
    dir_rows.push_back(mk_row(MODE_REMOVE, 0, 0, 0, 0, 0, 0, 0));
    dir_rows.push_back(mk_row(MODE_MOVE, 5, 0, 0, 0, 0, 0, 0));
    dir_rows.push_back(mk_row(MODE_INSERT, 16, 16, 0, 0, 0, 0, 0));
    dir_rows.push_back(mk_row(MODE_INSERT, 1, 16, 0, 0, 0, 0, 0));
    dir_rows.push_back(mk_row(MODE_INSERT, 2, 16, 0, 0, 0, 0, 0));
    dir_rows.push_back(mk_row(MODE_REMOVE, 1, 0, 0, 0, 0, 0, 0));
    dir_rows.push_back(mk_row(MODE_MOVE, 31, 0, 0, 0, 0, 0, 0));
    dir_rows.push_back(mk_row(MODE_UNUSED, 9, 31, 0, 0, 0, 0, 0));
    dir_rows.push_back(mk_row(MODE_MOVE, 16, 31, 0, 0, 0, 0, 0));
    dir_rows.push_back(mk_row(MODE_REMOVE, 9, 0, 0, 0, 0, 0, 0));
    dir_rows.push_back(mk_row(MODE_REMOVE, 5, 0, 0, 0, 0, 0, 0));
    dir_rows.push_back(mk_row(MODE_REMOVE, 31, 0, 0, 0, 0, 0, 0));
    // move of a thread that is not ready
    dir_rows.push_back(mk_row(MODE_MOVE, 4, 0, 0, 0, 0, 0, 0));
    dir_rows.push_back(mk_row(MODE_REMOVE, 2, 0, 0, 0, 0, 0, 0));
    // last thread leaves: nothing ready
    dir_rows.push_back(mk_row(MODE_REMOVE, 16, 0, 1, 0, 0, 0, 0));

    while (!rst_ni) @(posedge clk_i);
    @(posedge clk_i);
    foreach (dir_rows[i]) send_op(dir_rows[i].cmd, dir_rows[i].typed, dir_rows[i].res);
    for (int n = 0; n < RANDOM_OPS; n++) begin
      c = pick_op();
      send_op(c, 1'b0, none);
    end
    s_axis_tvalid <= 1'b0;

    while (sched_expect_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    $display("covered %0d operations: %0d inserts, %0d removes, %0d moves, %0d rejected",
             ops_sent, n_insert, n_remove, n_move, n_rejected);
    $display("%0d results compared, up to %0d threads ready, one %0d-cycle output hold-off",
             results_seen, deepest_ready, HOLD_OFF_CYCLES);
    if (mismatch_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // long output hold-off while operations keep coming
  initial begin : output_hold_off
    while (ops_sent < 400) @(posedge clk_i);
    hold_off <= 1'b1;
    repeat (HOLD_OFF_CYCLES) @(posedge clk_i);
    hold_off <= 1'b0;
  end

  // result side: compare each transaction, then pick the next ready value
  always @(posedge clk_i) begin : result_check
    pbrs_res_t got;
    pbrs_res_t want;
    int        style;
    int        cyc;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready) begin
      got.highest_valid = m_axis_tdata_o[0];
      got.highest_thread = m_axis_tdata_o[5:1];
      got.highest_priority = m_axis_tdata_o[10:6];
      got.op_error = m_axis_tdata_o[11];
      if (sched_expect_q.size() == 0) begin
        report_mismatch($sformatf("unexpected result %h", m_axis_tdata_o));
      end else begin
        want = sched_expect_q.pop_front();
        check_field("highest_valid", got.highest_valid, want.highest_valid);
        check_field("highest_thread", got.highest_thread, want.highest_thread);
        check_field("highest_priority", got.highest_priority, want.highest_priority);
        check_field("op_error", got.op_error, want.op_error);
      end
      results_seen++;
    end
    // stall style is drawn at random from: always ready, coin flip, fixed pattern
    cyc++;
    if (cyc % 64 == 0) style = $urandom_range(0, 2);
    if (hold_off) m_axis_tready <= 1'b0;
    else if (style == 0) m_axis_tready <= 1'b1;
    else if (style == 1) m_axis_tready <= 1'($urandom_range(0, 1));
    else m_axis_tready <= STALL_PATTERN[cyc % 8];
  end

endmodule

>>> sim.f
design/pbrs_pkg.sv
design/pbrs_ffs.sv
design/pbrs_ready_lists.sv
design/priority_bitmap_ready_scheduler.sv
design/pbrs_checker.sv
tb/sv/testbench.sv
